// ----- src/fes_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Enrollment sequencer package
// Shared types, event codes and status constants for the enrollment
// sequencer front end, result queue and output stage.
// ----------------------------------------------------------------------------
package fes_pkg;

  // Number of template slots the sensor module offers.
  localparam int SLOT_COUNT = 256;

  // Sensor module status codes.
  localparam logic [7:0] STAT_OK        = 8'd0;
  localparam logic [7:0] STAT_NO_FINGER = 8'd2;
  localparam logic [7:0] STAT_MISMATCH  = 8'd10;

  // Timer limits and reset value.
  localparam logic [19:0] ELAPSED_MAX     = 20'hFFFFF;
  localparam logic [19:0] TIMEOUT_DEFAULT = 20'd30000;

  // Input actions.
  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_CANCEL = 2'd1;
  localparam logic [1:0] ACT_POLL   = 2'd2;
  localparam logic [1:0] ACT_TICK   = 2'd3;

  // Enrollment stages.
  localparam logic [1:0] STG_PRESS1 = 2'd0;
  localparam logic [1:0] STG_LIFT   = 2'd1;
  localparam logic [1:0] STG_PRESS2 = 2'd2;

  // Result events.
  localparam logic [3:0] EV_WAIT1      = 4'd0;
  localparam logic [3:0] EV_PRESS1_OK  = 4'd1;
  localparam logic [3:0] EV_LIFT       = 4'd2;
  localparam logic [3:0] EV_WAIT2      = 4'd3;
  localparam logic [3:0] EV_DONE       = 4'd4;
  localparam logic [3:0] EV_TIMEOUT    = 4'd5;
  localparam logic [3:0] EV_IMAGE_FAIL = 4'd6;
  localparam logic [3:0] EV_MISMATCH   = 4'd7;
  localparam logic [3:0] EV_MODEL_FAIL = 4'd8;
  localparam logic [3:0] EV_STORE_FAIL = 4'd9;
  localparam logic [3:0] EV_CANCELED   = 4'd10;

  // Result queue depth.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Input transaction payload.
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] slot_id;
    logic [7:0] image_code;
    logic [7:0] extract_code;
    logic [7:0] merge_code;
    logic [7:0] store_code;
  } fes_in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [3:0] event_res;
    logic [7:0] slot;
    logic [7:0] detail_code;
    logic       has_detail;
    logic       last;
  } fes_out_t;

  // One queued job: a single event, or the first-press pair
  // (first press accepted, followed by lift) when pair is set.
  typedef struct packed {
    logic [3:0] event_res;
    logic [7:0] slot;
    logic [7:0] detail_code;
    logic       has_detail;
    logic       pair;
  } fes_job_t;

  // Queue status toward the front end.
  typedef struct packed {
    logic full;
    logic empty;
  } fes_qstat_t;

endpackage
`default_nettype wire

// ----- src/fes_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Enrollment sequencer front end
// Accepts input transactions, tracks the enrollment stage and timer, and
// pushes one result job per input that produces results.
// ----------------------------------------------------------------------------
module fes_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_we,
  input  wire [19:0]          cfg_wdata,
  input  wire                 in_valid,
  output logic                in_stall,
  input  fes_pkg::fes_in_t    in_data,
  input  fes_pkg::fes_qstat_t qstat,
  output logic                push,
  output fes_pkg::fes_job_t   push_job
);
  import fes_pkg::*;

  logic        busy_r, busy_nxt;
  logic [1:0]  stage_r, stage_nxt;
  logic [7:0]  slot_r, slot_nxt;
  logic [19:0] elapsed_r, elapsed_nxt;
  logic [19:0] timeout_r;
  logic        accept;
  logic        slot_ok;

  // A full queue holds off every input.
  assign in_stall = qstat.full;
  assign accept   = in_valid && !in_stall;
  assign slot_ok  = ({3'b000, in_data.slot_id} < 11'(SLOT_COUNT));

  // Sequencer decode for one accepted transaction.
  always_comb begin
    busy_nxt    = busy_r;
    stage_nxt   = stage_r;
    slot_nxt    = slot_r;
    elapsed_nxt = elapsed_r;
    push        = 1'b0;
    push_job    = '{event_res: EV_WAIT1, slot: slot_r, detail_code: 8'd0,
                    has_detail: 1'b0, pair: 1'b0};
    if (accept) begin
      case (in_data.action)
        ACT_START: begin
          if (slot_ok) begin
            busy_nxt          = 1'b1;
            stage_nxt         = STG_PRESS1;
            slot_nxt          = in_data.slot_id;
            elapsed_nxt       = 20'd0;
            push              = 1'b1;
            push_job.event_res = EV_WAIT1;
            push_job.slot     = in_data.slot_id;
          end
        end
        ACT_CANCEL: begin
          busy_nxt           = 1'b0;
          push               = 1'b1;
          push_job.event_res = EV_CANCELED;
        end
        ACT_TICK: begin
          if (busy_r && elapsed_r != ELAPSED_MAX) begin
            elapsed_nxt = elapsed_r + 20'd1;
          end
        end
        default: begin
          // Poll: check the timer first, then the current stage.
          if (busy_r) begin
            if (elapsed_r > timeout_r) begin
              busy_nxt           = 1'b0;
              push               = 1'b1;
              push_job.event_res = EV_TIMEOUT;
            end else if (stage_r == STG_PRESS1) begin
              if (in_data.image_code == STAT_OK) begin
                push = 1'b1;
                if (in_data.extract_code != STAT_OK) begin
                  busy_nxt             = 1'b0;
                  push_job.event_res   = EV_IMAGE_FAIL;
                  push_job.detail_code = in_data.extract_code;
                  push_job.has_detail  = 1'b1;
                end else begin
                  stage_nxt          = STG_LIFT;
                  elapsed_nxt        = 20'd0;
                  push_job.event_res = EV_PRESS1_OK;
                  push_job.pair      = 1'b1;
                end
              end
            end else if (stage_r == STG_LIFT) begin
              if (in_data.image_code == STAT_NO_FINGER) begin
                stage_nxt          = STG_PRESS2;
                elapsed_nxt        = 20'd0;
                push               = 1'b1;
                push_job.event_res = EV_WAIT2;
              end
            end else begin
              // Second press: once an image is taken, every outcome ends the enrollment.
              if (in_data.image_code == STAT_OK) begin
                busy_nxt = 1'b0;
                push     = 1'b1;
                if (in_data.extract_code != STAT_OK) begin
                  push_job.event_res   = EV_IMAGE_FAIL;
                  push_job.detail_code = in_data.extract_code;
                  push_job.has_detail  = 1'b1;
                end else if (in_data.merge_code == STAT_MISMATCH) begin
                  push_job.event_res = EV_MISMATCH;
                end else if (in_data.merge_code != STAT_OK) begin
                  push_job.event_res   = EV_MODEL_FAIL;
                  push_job.detail_code = in_data.merge_code;
                  push_job.has_detail  = 1'b1;
                end else if (in_data.store_code != STAT_OK) begin
                  push_job.event_res   = EV_STORE_FAIL;
                  push_job.detail_code = in_data.store_code;
                  push_job.has_detail  = 1'b1;
                end else begin
                  push_job.event_res = EV_DONE;
                end
              end
            end
          end
        end
      endcase
    end
  end

  // Sequencer state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      stage_r   <= STG_PRESS1;
      slot_r    <= 8'd0;
      elapsed_r <= 20'd0;
    end else begin
      busy_r    <= busy_nxt;
      stage_r   <= stage_nxt;
      slot_r    <= slot_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  // Timeout configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_DEFAULT;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

endmodule
`default_nettype wire

// ----- src/fes_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Enrollment sequencer job queue
// Small first-in first-out queue of result jobs between the front end and
// the output stage.
// ----------------------------------------------------------------------------
module fes_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  fes_pkg::fes_job_t   push_job,
  input  wire                 pop,
  output fes_pkg::fes_job_t   head_job,
  output fes_pkg::fes_qstat_t qstat
);
  import fes_pkg::*;

  fes_job_t       mem_r [QDEPTH];
  logic [QAW-1:0] wptr_r, rptr_r;
  logic [QAW:0]   count_r;
  logic           do_push, do_pop;

  assign qstat.full  = (count_r == (QAW+1)'(QDEPTH));
  assign qstat.empty = (count_r == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head_job    = mem_r[rptr_r];

  // Job storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + QAW'(1);
      end
      if (do_pop) begin
        rptr_r <= rptr_r + QAW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (QAW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (QAW+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/fes_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Enrollment sequencer output stage
// Pops result jobs and presents them as result transactions, expanding the
// first-press pair into the first-press event followed by lift.
// ----------------------------------------------------------------------------
module fes_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  fes_pkg::fes_job_t   head_job,
  input  fes_pkg::fes_qstat_t qstat,
  output logic                pop,
  output logic                out_valid,
  input  wire                 out_stall,
  output fes_pkg::fes_out_t   out_data
);
  import fes_pkg::*;

  logic     valid_r;
  logic     lift_pend_r;
  fes_out_t data_r;
  logic     load;

  // The output register may load when empty or when its transaction leaves.
  assign load      = !valid_r || !out_stall;
  assign pop       = load && !lift_pend_r && !qstat.empty;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // Control: valid flag and pending second event of a pair.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      lift_pend_r <= 1'b0;
    end else if (load) begin
      if (lift_pend_r) begin
        valid_r     <= 1'b1;
        lift_pend_r <= 1'b0;
      end else begin
        valid_r     <= !qstat.empty;
        lift_pend_r <= !qstat.empty && head_job.pair;
      end
    end
  end

  // Payload of the presented result.
  always_ff @(posedge clk) begin
    if (load) begin
      if (lift_pend_r) begin
        data_r.event_res <= EV_LIFT;
        data_r.last      <= 1'b1;
      end else begin
        data_r.event_res   <= head_job.event_res;
        data_r.slot        <= head_job.slot;
        data_r.detail_code <= head_job.detail_code;
        data_r.has_detail  <= head_job.has_detail;
        data_r.last        <= !head_job.pair;
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/fingerprint_enroll_sequencer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fingerprint enrollment sequencer
// Two-press enrollment control: start, cancel, sensor poll and tick inputs
// drive a stage machine that reports progress, completion and failures.
//
// Usage: the input channel (in_valid, in_stall, in_data) takes one
// transaction per cycle while the internal job queue has room. The
// front end updates the stage, slot and timer in the cycle a transaction is
// accepted. Each input yields zero, one or two result transactions on the
// output channel (out_valid, out_stall, out_data); the first passes through
// the job queue and the output register before it is presented, and leaves
// at the next edge when out_stall is low.
// A first-press success produces two results, the first-press event then
// lift, so while out_stall is low the output side sustains one result per
// cycle and the input side one item per cycle whenever results do not pile
// up. When the receiver stalls, results wait in the output register and a
// four-entry queue; once the queue is full in_stall rises. cfg_we/cfg_wdata
// write the timeout in ticks. Synchronous reset clears the stage machine,
// the queue and the output, and restores the timeout to 30000 ticks.
// ----------------------------------------------------------------------------
module fingerprint_enroll_sequencer (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               cfg_we,
  input  wire [19:0]        cfg_wdata,
  input  wire               in_valid,
  output logic              in_stall,
  input  fes_pkg::fes_in_t  in_data,
  output logic              out_valid,
  input  wire               out_stall,
  output fes_pkg::fes_out_t out_data
);
  import fes_pkg::*;

  fes_qstat_t qstat;
  fes_job_t   push_job;
  fes_job_t   head_job;
  logic       push;
  logic       pop;

  fes_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .qstat     (qstat),
    .push      (push),
    .push_job  (push_job)
  );

  fes_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .qstat    (qstat)
  );

  fes_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_job  (head_job),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
